FILE: hdl/rcis_pkg.sv
package rcis_pkg;

   localparam int MAX_RANGES = 16;
   localparam int KEY_BITS = 32;
   localparam int CNT_BITS = $clog2(MAX_RANGES + 1);

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_POP    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // per-cell action decided by the controller
   typedef enum logic [2:0] {
      ACT_HOLD    = 3'd0,
      ACT_SET_LO  = 3'd1,
      ACT_SET_HI  = 3'd2,
      ACT_FROM_UP = 3'd3,
      ACT_FROM_DN = 3'd4,
      ACT_LOAD    = 3'd5
   } act_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SEARCH = 2'd1,
      S_APPLY  = 2'd2,
      S_DONE   = 2'd3
   } state_type;

   // per-cell compare flags
   typedef struct packed {
      logic hi_lt_k;
      logic lo_le_k;
   } cmp_type;

   // per-cell write command
   typedef struct packed {
      act_type act;
      key_type lo;
      key_type hi;
   } cell_ctl_type;

endpackage

FILE: hdl/rcis_cell.sv
module rcis_cell (
   input  logic                   clock,
   input  rcis_pkg::cell_ctl_type ctl,
   input  rcis_pkg::key_type      key,
   input  rcis_pkg::key_type      up_lo,
   input  rcis_pkg::key_type      up_hi,
   input  rcis_pkg::key_type      dn_lo,
   input  rcis_pkg::key_type      dn_hi,
   output rcis_pkg::key_type      lo,
   output rcis_pkg::key_type      hi,
   output rcis_pkg::cmp_type      cmp
);
   import rcis_pkg::*;

   key_type lo_ff, hi_ff, lo_in, hi_in;

   // compare stored range against the key
   assign cmp.hi_lt_k = hi_ff < key;
   assign cmp.lo_le_k = lo_ff <= key;
   assign lo = lo_ff;
   assign hi = hi_ff;

   // select new contents
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      case (ctl.act)
         ACT_HOLD: ;
         ACT_SET_LO: lo_in = ctl.lo;
         ACT_SET_HI: hi_in = ctl.hi;
         ACT_FROM_UP: begin
            lo_in = up_lo;
            hi_in = up_hi;
         end
         ACT_FROM_DN: begin
            lo_in = dn_lo;
            hi_in = dn_hi;
         end
         ACT_LOAD: begin
            lo_in = ctl.lo;
            hi_in = ctl.hi;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end
endmodule

FILE: hdl/range_compressed_integer_set.sv
// result word valid once the command has passed through the search and apply states after acceptance
// a new command is taken only after the previous response is accepted (capture, search, apply, done)
// every cell compares in parallel; insert, remove and pop shift the row by one cell, all cells at once in apply
// reset: synchronous, active high; clears the range count so the set starts empty
// range bounds hold no reset value and are read only below the range count
module range_compressed_integer_set (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_popped_key,
   output logic [4:0]  rsp_range_total
);
   import rcis_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_RANGES);

   state_type  state_ff, state_in;
   cmd_type    cmd_ff;
   key_type    key_ff;
   cnt_type    used_ff, used_in;
   cnt_type    slot_ff, slot_in;
   status_type st_ff, st_in;
   key_type    pop_ff, pop_in;

   key_type      lo_w [MAX_RANGES];
   key_type      hi_w [MAX_RANGES];
   cmp_type      cmp_w [MAX_RANGES];
   cell_ctl_type ctl_w [MAX_RANGES];

   // row of cells
   for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
      localparam int UP = (g == 0) ? 0 : g - 1;
      localparam int DN = (g == MAX_RANGES - 1) ? g : g + 1;
      rcis_cell u_cell (
         .clock (clock),
         .ctl   (ctl_w[g]),
         .key   (key_ff),
         .up_lo (lo_w[UP]),
         .up_hi (hi_w[UP]),
         .dn_lo (lo_w[DN]),
         .dn_hi (hi_w[DN]),
         .lo    (lo_w[g]),
         .hi    (hi_w[g]),
         .cmp   (cmp_w[g])
      );
   end

   // find first slot whose high bound is not below the key
   always_comb begin
      slot_in = used_ff;
      for (int i = MAX_RANGES - 1; i >= 0; i--) begin
         if (cnt_type'(i) < used_ff && !cmp_w[i].hi_lt_k) slot_in = cnt_type'(i);
      end
   end

   logic [IDX_BITS-1:0] s_idx, p_idx;
   logic in_rng, has_prev, left, right, is_lo, is_hi, one_key, full;
   key_type s_lo, s_hi, p_hi;

   assign s_idx   = slot_ff[IDX_BITS-1:0];
   assign p_idx   = s_idx - 1'b1;
   assign s_lo    = lo_w[s_idx];
   assign s_hi    = hi_w[s_idx];
   assign p_hi    = hi_w[p_idx];
   assign in_rng  = slot_ff < used_ff;
   assign has_prev = slot_ff != '0;
   assign full    = used_ff == cnt_type'(MAX_RANGES);
   assign left    = has_prev && (p_hi + 1'b1 == key_ff);
   assign right   = in_rng && (key_ff + 1'b1 == s_lo);
   assign is_lo   = key_ff == s_lo;
   assign is_hi   = key_ff == s_hi;
   assign one_key = s_lo == s_hi;

   // controller: next state and cell commands
   always_comb begin
      state_in = state_ff;
      used_in  = used_ff;
      st_in    = st_ff;
      pop_in   = pop_ff;
      for (int i = 0; i < MAX_RANGES; i++) begin
         ctl_w[i].act = ACT_HOLD;
         ctl_w[i].lo  = key_ff;
         ctl_w[i].hi  = key_ff;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SEARCH;
         end
         S_SEARCH: state_in = S_APPLY;
         S_APPLY: begin
            state_in = S_DONE;
            st_in    = ST_OK;
            pop_in   = '0;
            case (cmd_ff)
               CMD_INSERT: begin
                  if (in_rng && !cmp_w[s_idx].lo_le_k) begin
                     if (left && right) begin
                        ctl_w[p_idx].act = ACT_SET_HI;
                        ctl_w[p_idx].hi  = s_hi;
                        for (int i = 0; i < MAX_RANGES; i++)
                           if (cnt_type'(i) >= slot_ff && cnt_type'(i) + 1'b1 < used_ff)
                              ctl_w[i].act = ACT_FROM_DN;
                        used_in = used_ff - 1'b1;
                     end else if (left) begin
                        ctl_w[p_idx].act = ACT_SET_HI;
                     end else if (right) begin
                        ctl_w[s_idx].act = ACT_SET_LO;
                     end else if (full) begin
                        st_in = ST_FULL;
                     end else begin
                        for (int i = 0; i < MAX_RANGES; i++)
                           if (cnt_type'(i) > slot_ff && cnt_type'(i) <= used_ff)
                              ctl_w[i].act = ACT_FROM_UP;
                        ctl_w[s_idx].act = ACT_LOAD;
                        used_in = used_ff + 1'b1;
                     end
                  end else if (!in_rng) begin
                     if (left) begin
                        ctl_w[p_idx].act = ACT_SET_HI;
                     end else if (full) begin
                        st_in = ST_FULL;
                     end else begin
                        ctl_w[s_idx].act = ACT_LOAD;
                        used_in = used_ff + 1'b1;
                     end
                  end
               end
               CMD_POP: begin
                  if (used_ff == '0) begin
                     st_in = ST_EMPTY;
                  end else begin
                     pop_in = lo_w[0];
                     if (lo_w[0] == hi_w[0]) begin
                        for (int i = 0; i < MAX_RANGES; i++)
                           if (cnt_type'(i) + 1'b1 < used_ff) ctl_w[i].act = ACT_FROM_DN;
                        used_in = used_ff - 1'b1;
                     end else begin
                        ctl_w[0].act = ACT_SET_LO;
                        ctl_w[0].lo  = lo_w[0] + 1'b1;
                     end
                  end
               end
               CMD_REMOVE: begin
                  if (!in_rng || !cmp_w[s_idx].lo_le_k) begin
                     st_in = ST_NOT_FOUND;
                  end else if (one_key) begin
                     for (int i = 0; i < MAX_RANGES; i++)
                        if (cnt_type'(i) >= slot_ff && cnt_type'(i) + 1'b1 < used_ff)
                           ctl_w[i].act = ACT_FROM_DN;
                     used_in = used_ff - 1'b1;
                  end else if (is_lo) begin
                     ctl_w[s_idx].act = ACT_SET_LO;
                     ctl_w[s_idx].lo  = key_ff + 1'b1;
                  end else if (is_hi) begin
                     ctl_w[s_idx].act = ACT_SET_HI;
                     ctl_w[s_idx].hi  = key_ff - 1'b1;
                  end else if (full) begin
                     st_in = ST_FULL;
                  end else begin
                     for (int i = 0; i < MAX_RANGES; i++)
                        if (cnt_type'(i) > slot_ff + 1'b1 && cnt_type'(i) <= used_ff)
                           ctl_w[i].act = ACT_FROM_UP;
                     ctl_w[s_idx].act = ACT_SET_HI;
                     ctl_w[s_idx].hi  = key_ff - 1'b1;
                     ctl_w[p_idx + 2'd2].act = ACT_LOAD;
                     ctl_w[p_idx + 2'd2].lo  = key_ff + 1'b1;
                     ctl_w[p_idx + 2'd2].hi  = s_hi;
                     used_in = used_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_DONE: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= cmd_type'(req_command);
         key_ff <= key_type'(req_key);
      end
      slot_ff <= slot_in;
      st_ff   <= st_in;
      pop_ff  <= pop_in;
   end

   assign req_ready       = state_ff == S_IDLE;
   assign rsp_valid       = state_ff == S_DONE;
   assign rsp_status      = st_ff;
   assign rsp_popped_key  = 32'(pop_ff);
   assign rsp_range_total = 5'(used_ff);

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= cnt_type'(MAX_RANGES))
      else $error("range count above table size");
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_APPLY |=> (used_ff == $past(used_ff) ||
         used_ff == $past(used_ff) + 1'b1 || used_ff == $past(used_ff) - 1'b1))
      else $error("range count moved by more than one");
   a_full_ok: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_APPLY && st_in == ST_FULL |=> $stable(used_ff))
      else $error("full status but count changed");
   a_pop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_popped_key == '0)
      else $error("popped key set on failed command");
`endif
endmodule
